### rtl/lbat_pkg.sv
// ----------------------------------------------------------------------------
// lbat_pkg: shared types and constants for the budgeted allocation table
// Holds request and status codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package lbat_pkg;

  localparam int TableSlots = 16;
  localparam int SlotBits   = $clog2(TableSlots);
  localparam int KeyBits    = 32;
  localparam int ByteBits   = 48;
  localparam int StampBits  = 32;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_ACCESS  = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_NO_ROOM   = 3'd2;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_DONE      = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EVICT,
    S_FINISH,
    S_OUT
  } seq_state_t;

endpackage

### rtl/lru_budget_allocation_table_top.sv
// ----------------------------------------------------------------------------
// lru_budget_allocation_table_top: allocation table under a byte budget
// Keys, sizes and stamps live in a slot memory that is scanned one slot a cycle.
// ----------------------------------------------------------------------------
// Flow: a request is accepted in idle, scans the slot memory through its single
// read port, is decided and then presents its result, waiting in the output
// state until out_ready takes it; each eviction adds another scan, decision and
// result. Throughput: one request at a time, as a new one is taken only in idle.
// Reset: synchronous; clears valid bits, byte counts, tick and budget.
module lru_budget_allocation_table_top
  import lbat_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ByteBits-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [KeyBits-1:0]  entry_key,
  input  logic [ByteBits-1:0] byte_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic                is_eviction,
  output logic [KeyBits-1:0]  result_key,
  output logic [ByteBits-1:0] freed_bytes,
  output logic [ByteBits-1:0] used_total,
  output logic [ByteBits-1:0] peak_total,
  output logic                last_result
);

  localparam int EntryBits = KeyBits + ByteBits + StampBits;

  // Slot memory: key, size and stamp of each slot; valid bits sit in flops.
  logic [EntryBits-1:0] slot_mem [TableSlots];
  logic [EntryBits-1:0] rd_data;
  logic [SlotBits-1:0]  rd_addr;
  logic                 wr_en;
  logic [SlotBits-1:0]  wr_addr;
  logic [EntryBits-1:0] wr_data;
  logic [TableSlots-1:0] slot_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data <= slot_mem[rd_addr];
  end

  logic [ByteBits-1:0]  byte_budget;
  logic [ByteBits-1:0]  bytes_in_use;
  logic [ByteBits-1:0]  bytes_peak;
  logic [StampBits-1:0] access_tick;

  seq_state_t state, state_next;

  // Request registers.
  logic [1:0]          rq_type;
  logic [KeyBits-1:0]  rq_key;
  logic [ByteBits-1:0] rq_size;

  // Scan bookkeeping: address issued, slot whose data is returning.
  logic [SlotBits:0]   scan_cnt;
  logic                rd_live;
  logic [SlotBits-1:0] rd_slot;
  logic                hit;
  logic [SlotBits-1:0] hit_slot;
  logic [ByteBits-1:0] hit_bytes;
  logic                old_found;
  logic [SlotBits-1:0] old_slot;
  logic [StampBits-1:0] old_age;
  logic [ByteBits-1:0] old_bytes;
  logic [KeyBits-1:0]  old_key;
  logic                first_scan;

  // Result register.
  logic [2:0]          o_status;
  logic                o_evict;
  logic [KeyBits-1:0]  o_key;
  logic [ByteBits-1:0] o_freed;
  logic                o_last;
  logic                out_full;

  logic [KeyBits-1:0]   rd_key;
  logic [ByteBits-1:0]  rd_bytes;
  logic [StampBits-1:0] rd_stamp;
  logic [StampBits-1:0] rd_age;
  logic [ByteBits:0]    need;
  logic                 over;
  logic                 free_any;
  logic [SlotBits-1:0]  free_slot;

  assign rd_key   = rd_data[EntryBits-1 -: KeyBits];
  assign rd_bytes = rd_data[StampBits +: ByteBits];
  assign rd_stamp = rd_data[StampBits-1:0];
  assign rd_age   = access_tick - rd_stamp;
  assign need     = {1'b0, bytes_in_use} + {1'b0, rq_size};
  assign over     = need > {1'b0, byte_budget};
  assign rd_addr  = scan_cnt[SlotBits-1:0];

  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = TableSlots - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_any  = 1'b1;
        free_slot = SlotBits'(i);
      end
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = out_full;
  assign status = o_status;
  assign is_eviction = o_evict;
  assign result_key = o_key;
  assign freed_bytes = o_freed;
  assign used_total = bytes_in_use;
  assign peak_total = bytes_peak;
  assign last_result = o_last;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && req_type != REQ_UNUSED) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == (SlotBits+1)'(TableSlots) && !rd_live) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: state_next = S_OUT;
      S_EVICT:  state_next = S_OUT;
      S_FINISH: state_next = S_OUT;
      S_OUT: begin
        if (!out_full) begin
          state_next = o_last ? S_IDLE : S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      byte_budget  <= '0;
      bytes_in_use <= '0;
      bytes_peak   <= '0;
      access_tick  <= '0;
      slot_valid   <= '0;
      out_full     <= 1'b0;
      scan_cnt     <= '0;
      rd_live      <= 1'b0;
    end else begin
      if (cfg_we) begin
        byte_budget <= cfg_wdata;
      end
      if (out_full && out_ready) begin
        out_full <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          rq_type    <= req_type;
          rq_key     <= entry_key;
          rq_size    <= byte_count;
          first_scan <= 1'b1;
          scan_cnt   <= '0;
          rd_live    <= 1'b0;
          hit        <= 1'b0;
          old_found  <= 1'b0;
        end
        S_SCAN: begin
          // Issue one read a cycle and fold in the data of the previous one.
          if (scan_cnt != (SlotBits+1)'(TableSlots)) begin
            scan_cnt <= scan_cnt + (SlotBits+1)'(1);
            rd_live  <= 1'b1;
            rd_slot  <= scan_cnt[SlotBits-1:0];
          end else begin
            rd_live <= 1'b0;
          end
          if (rd_live && slot_valid[rd_slot]) begin
            if (rd_key == rq_key && !hit) begin
              hit       <= 1'b1;
              hit_slot  <= rd_slot;
              hit_bytes <= rd_bytes;
            end
            if (!old_found || rd_age > old_age) begin
              old_found <= 1'b1;
              old_slot  <= rd_slot;
              old_age   <= rd_age;
              old_bytes <= rd_bytes;
              old_key   <= rd_key;
            end
          end
        end
        S_DECIDE: begin
          out_full <= 1'b1;
          o_evict  <= 1'b0;
          o_key    <= rq_key;
          o_freed  <= '0;
          o_last   <= 1'b1;
          priority if (rq_type == REQ_RELEASE) begin
            if (hit) begin
              slot_valid[hit_slot] <= 1'b0;
              bytes_in_use <= bytes_in_use - hit_bytes;
              o_status <= ST_DONE;
              o_freed  <= hit_bytes;
            end else begin
              o_status <= ST_NOT_FOUND;
            end
          end else if (rq_type == REQ_ACCESS) begin
            if (hit) begin
              wr_en   <= 1'b1;
              wr_addr <= hit_slot;
              wr_data <= {rq_key, hit_bytes, access_tick};
              access_tick <= access_tick + StampBits'(1);
              o_status <= ST_DONE;
            end else begin
              o_status <= ST_NOT_FOUND;
            end
          end else if (hit && first_scan) begin
            o_status <= ST_PRESENT;
          end else if (over && old_found) begin
            // Evict the oldest live slot and rescan afterwards.
            slot_valid[old_slot] <= 1'b0;
            bytes_in_use <= bytes_in_use - old_bytes;
            o_status <= ST_DONE;
            o_evict  <= 1'b1;
            o_key    <= old_key;
            o_freed  <= old_bytes;
            o_last   <= 1'b0;
          end else if (over) begin
            o_status <= ST_NO_ROOM;
          end else if (rq_size == '0) begin
            o_status <= ST_ZERO_SIZE;
          end else if (!free_any) begin
            o_status <= ST_FULL;
          end else begin
            slot_valid[free_slot] <= 1'b1;
            wr_en   <= 1'b1;
            wr_addr <= free_slot;
            wr_data <= {rq_key, rq_size, access_tick};
            access_tick  <= access_tick + StampBits'(1);
            bytes_in_use <= need[ByteBits-1:0];
            if (need[ByteBits-1:0] > bytes_peak) begin
              bytes_peak <= need[ByteBits-1:0];
            end
            o_status <= ST_ALLOCATED;
          end
        end
        S_OUT: begin
          if (!out_full) begin
            first_scan <= 1'b0;
            scan_cnt   <= '0;
            rd_live    <= 1'b0;
            hit        <= 1'b0;
            old_found  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The result register is loaded only from the decision step.
  property p_out_from_decide;
    @(posedge clk) disable iff (rst) $rose(out_full) |-> $past(state == S_DECIDE);
  endproperty
  a_out_from_decide: assert property (p_out_from_decide)
    else $error("result loaded outside decision step");

  // No new request while a result is pending.
  property p_busy;
    @(posedge clk) disable iff (rst) out_full |-> !in_ready;
  endproperty
  a_busy: assert property (p_busy) else $error("request taken with result pending");

  // Peak never falls below the bytes in use.
  property p_peak;
    @(posedge clk) disable iff (rst) state == S_IDLE |-> bytes_peak >= bytes_in_use;
  endproperty
  a_peak: assert property (p_peak) else $error("peak below usage");

endmodule
